@@ rtl/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the step sequencer core: request codes,
// register indexes, message constants and the control state type.
// ----------------------------------------------------------------------------
package mss_pkg;

   // request kinds carried in req_type
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // configuration register indexes
   localparam int          CSR_IDX_W       = 2;
   localparam int          CSR_DATA_W      = 16;
   localparam logic [1:0]  CSR_STEP_PERIOD = 2'd0;
   localparam logic [1:0]  CSR_SWING_TICKS = 2'd1;

   // register reset values
   localparam logic [15:0] STEP_PERIOD_RST = 16'd99;
   localparam logic [15:0] SWING_TICKS_RST = 16'd33;

   // step timer width
   localparam int TIMER_W = 17;

   // note-on message constants
   localparam logic [7:0] STATUS_NOTE_ON = 8'd144;
   localparam logic [6:0] NOTE_BASE      = 7'd36;
   localparam logic [6:0] NOTE_VELOCITY  = 7'd100;

   // results per played step are capped
   localparam int         COUNT_W     = 7;
   localparam logic [6:0] MAX_RESULTS = 7'd64;

   // control sequencer
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WRITE = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

@@ rtl/mss_if.sv @@
// ----------------------------------------------------------------------------
// mss_if
// Valid/ready channels of the step sequencer: request beats (ticks and grid
// writes) and result beats (note-on messages).
// ----------------------------------------------------------------------------
interface mss_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] cell_channel;
   logic [2:0] cell_row;
   logic [3:0] cell_step;
   logic       cell_on;

   modport source (output valid, req_type, cell_channel, cell_row, cell_step, cell_on,
                   input ready);
   modport sink   (input valid, req_type, cell_channel, cell_row, cell_step, cell_on,
                   output ready);
endinterface

interface mss_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_note;
   logic [7:0] status_byte;
   logic [6:0] note_number;
   logic [6:0] velocity;
   logic       notes_off_first;
   logic [3:0] played_step;
   logic       last;

   modport source (output valid, has_note, status_byte, note_number, velocity,
                   notes_off_first, played_step, last,
                   input ready);
   modport sink   (input valid, has_note, status_byte, note_number, velocity,
                   notes_off_first, played_step, last,
                   output ready);
endinterface

@@ rtl/mss_grid_ram.sv @@
// ----------------------------------------------------------------------------
// mss_grid_ram
// Pattern grid storage: one row of step bits per channel/row pair. One write
// port, one registered read port. A per-entry valid bit makes entries never
// written since reset read back as all steps off.
// ----------------------------------------------------------------------------
module mss_grid_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] q_ff;
   logic              q_valid_ff;

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   // entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule

@@ rtl/midi_step_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// midi_step_sequencer_core
// Drum-style step sequencer: a channel x row x step on/off grid played out
// as note-on messages, one step per step timer expiry.
// ----------------------------------------------------------------------------
// A grid write beat reads the grid entry and then writes it back in ST_WRITE,
// and a tick beat that does not fire only counts the step timer down. A tick
// that fires scans every channel/row entry of the grid through the single
// read port of the grid RAM, one entry per cycle while the result channel does
// not stall, and holds off the request channel until its final result. Results
// come out in row order, channels within a row; the first result of a step
// carries notes_off_first and the final one carries last, and a step with no
// active cell gives a single result without a note. The grid is empty after
// reset at once (per-entry valid bits, no clearing pass). Registers:
// index 0 step_period (ticks per step, 0 acts as 1), index 1 swing_ticks
// (added on every other step after the first). Write them only while idle.
// ----------------------------------------------------------------------------
module midi_step_sequencer_core #(
   parameter int CHANNELS = 8,
   parameter int ROWS     = 8,
   parameter int STEPS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   mss_req_if.sink                        req,
   mss_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [mss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mss_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW     = $clog2(STEPS);
   localparam int ADDR_W = RW + CW;
   localparam int TW     = mss_pkg::TIMER_W;

   // configuration registers
   logic [15:0] period_ff;
   logic [15:0] swing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= mss_pkg::STEP_PERIOD_RST;
         swing_ff  <= mss_pkg::SWING_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            mss_pkg::CSR_STEP_PERIOD: period_ff <= csr_wdata;
            mss_pkg::CSR_SWING_TICKS: swing_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   mss_pkg::state_type state_ff, state_in;
   logic [SW-1:0]      step_ff, step_in;
   logic [TW-1:0]      cd_ff, cd_in;
   logic               started_ff, started_in;
   logic [SW-1:0]      play_ff, play_in;
   logic [RW-1:0]      row_cnt_ff, row_cnt_in;
   logic [CW-1:0]      ch_cnt_ff, ch_cnt_in;
   logic               scan_left_ff, scan_left_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [mss_pkg::COUNT_W-1:0] count_ff, count_in;
   logic               any_out_ff, any_out_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [RW-1:0]      rd_row_ff, rd_row_in;
   logic [CW-1:0]      rd_ch_ff, rd_ch_in;
   logic [RW-1:0]      pend_row_ff, pend_row_in;
   logic [CW-1:0]      pend_ch_ff, pend_ch_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [SW-1:0]      wr_bit_ff, wr_bit_in;
   logic               wr_on_ff, wr_on_in;

   logic               out_has_ff, out_first_ff, out_last_ff;
   logic [7:0]         out_status_ff;
   logic [6:0]         out_note_ff, out_vel_ff;
   logic [3:0]         out_step_ff;

   // grid RAM ports
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [STEPS-1:0]   rd_data;
   logic               wr_en;
   logic [STEPS-1:0]   wr_data;
   logic [STEPS-1:0]   wr_mask;

   // result push
   logic               push;
   logic               push_has, push_first, push_last;
   logic [RW-1:0]      push_row;
   logic [CW-1:0]      push_ch;

   logic               out_free;
   logic               hit_ok;
   logic               stall;
   logic               in_range;
   logic [TW-1:0]      interval;

   mss_grid_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (STEPS)
   ) u_grid (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign hit_ok   = rd_valid_ff && rd_data[play_ff] && (count_ff < mss_pkg::MAX_RESULTS);
   assign stall    = hit_ok && pend_valid_ff && !out_free;
   assign in_range = (32'(req.cell_channel) < CHANNELS) && (32'(req.cell_row) < ROWS) &&
                     (32'(req.cell_step) < STEPS);

   // next interval: swing on every other step once started, zero acts as one
   always_comb begin
      interval = TW'(period_ff);
      if (started_ff && !step_ff[0]) begin
         interval = interval + TW'(swing_ff);
      end
      if (interval == '0) begin
         interval = TW'(1);
      end
   end

   // read-modify-write of one grid entry
   assign wr_mask = STEPS'(1) << wr_bit_ff;
   assign wr_data = wr_on_ff ? (rd_data | wr_mask) : (rd_data & ~wr_mask);

   assign req.ready = (state_ff == mss_pkg::ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cd_in         = cd_ff;
      started_in    = started_ff;
      play_in       = play_ff;
      row_cnt_in    = row_cnt_ff;
      ch_cnt_in     = ch_cnt_ff;
      scan_left_in  = scan_left_ff;
      rd_valid_in   = rd_valid_ff;
      rd_row_in     = rd_row_ff;
      rd_ch_in      = rd_ch_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_ch_in    = pend_ch_ff;
      count_in      = count_ff;
      any_out_in    = any_out_ff;
      wr_addr_in    = wr_addr_ff;
      wr_bit_in     = wr_bit_ff;
      wr_on_in      = wr_on_ff;
      rd_en         = 1'b0;
      rd_addr       = {RW'(req.cell_row), CW'(req.cell_channel)};
      wr_en         = 1'b0;
      push          = 1'b0;
      push_has      = pend_valid_ff;
      push_row      = pend_row_ff;
      push_ch       = pend_ch_ff;
      push_first    = !any_out_ff;
      push_last     = 1'b0;

      case (state_ff)
         mss_pkg::ST_IDLE: begin
            if (req.valid) begin
               if (req.req_type == mss_pkg::REQ_WRITE) begin
                  if (in_range) begin
                     rd_en      = 1'b1;
                     wr_addr_in = rd_addr;
                     wr_bit_in  = SW'(req.cell_step);
                     wr_on_in   = req.cell_on;
                     state_in   = mss_pkg::ST_WRITE;
                  end
               end else if (cd_ff != '0) begin
                  cd_in = cd_ff - TW'(1);
               end else begin
                  // timer fired: reload, then play the current step
                  cd_in         = interval - TW'(1);
                  started_in    = 1'b1;
                  play_in       = step_ff;
                  step_in       = (32'(step_ff) == STEPS - 1) ? '0 : step_ff + SW'(1);
                  row_cnt_in    = '0;
                  ch_cnt_in     = '0;
                  scan_left_in  = 1'b1;
                  rd_valid_in   = 1'b0;
                  pend_valid_in = 1'b0;
                  count_in      = '0;
                  any_out_in    = 1'b0;
                  state_in      = mss_pkg::ST_SCAN;
               end
            end
         end

         mss_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = mss_pkg::ST_IDLE;
         end

         mss_pkg::ST_SCAN: begin
            if (!scan_left_ff && !rd_valid_ff) begin
               state_in = mss_pkg::ST_FLUSH;
            end else if (!stall) begin
               // issue the next entry read
               if (scan_left_ff) begin
                  rd_en       = 1'b1;
                  rd_addr     = {row_cnt_ff, ch_cnt_ff};
                  rd_valid_in = 1'b1;
                  rd_row_in   = row_cnt_ff;
                  rd_ch_in    = ch_cnt_ff;
                  if (32'(ch_cnt_ff) == CHANNELS - 1) begin
                     ch_cnt_in = '0;
                     if (32'(row_cnt_ff) == ROWS - 1) begin
                        scan_left_in = 1'b0;
                     end else begin
                        row_cnt_in = row_cnt_ff + RW'(1);
                     end
                  end else begin
                     ch_cnt_in = ch_cnt_ff + CW'(1);
                  end
               end else begin
                  rd_valid_in = 1'b0;
               end
               // an active cell retires the held one, which is then not last
               if (hit_ok) begin
                  count_in = count_ff + mss_pkg::COUNT_W'(1);
                  if (pend_valid_ff) begin
                     push       = 1'b1;
                     any_out_in = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = rd_row_ff;
                  pend_ch_in    = rd_ch_ff;
               end
            end
         end

         mss_pkg::ST_FLUSH: begin
            // held cell is the last one; no cell gives an empty result
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = mss_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mss_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mss_pkg::ST_IDLE;
         step_ff       <= '0;
         cd_ff         <= '0;
         started_ff    <= 1'b0;
         play_ff       <= '0;
         row_cnt_ff    <= '0;
         ch_cnt_ff     <= '0;
         scan_left_ff  <= 1'b0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         any_out_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cd_ff         <= cd_in;
         started_ff    <= started_in;
         play_ff       <= play_in;
         row_cnt_ff    <= row_cnt_in;
         ch_cnt_ff     <= ch_cnt_in;
         scan_left_ff  <= scan_left_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         any_out_ff    <= any_out_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_row_ff   <= rd_row_in;
      rd_ch_ff    <= rd_ch_in;
      pend_row_ff <= pend_row_in;
      pend_ch_ff  <= pend_ch_in;
      wr_addr_ff  <= wr_addr_in;
      wr_bit_ff   <= wr_bit_in;
      wr_on_ff    <= wr_on_in;
      if (push) begin
         out_has_ff    <= push_has;
         out_status_ff <= push_has ? (mss_pkg::STATUS_NOTE_ON + 8'(push_ch)) : 8'd0;
         out_note_ff   <= push_has ? (mss_pkg::NOTE_BASE + 7'(push_row)) : 7'd0;
         out_vel_ff    <= push_has ? mss_pkg::NOTE_VELOCITY : 7'd0;
         out_first_ff  <= push_first;
         out_step_ff   <= 4'(play_ff);
         out_last_ff   <= push_last;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.has_note        = out_has_ff;
   assign rsp.status_byte     = out_status_ff;
   assign rsp.note_number     = out_note_ff;
   assign rsp.velocity        = out_vel_ff;
   assign rsp.notes_off_first = out_first_ff;
   assign rsp.played_step     = out_step_ff;
   assign rsp.last            = out_last_ff;

endmodule
